// ===== src/art_pkg.sv =====
// shared types and constants of the ack retransmit tracker
package art_pkg;

  localparam int unsigned SlotsDef   = 16;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  localparam logic [15:0] AckTimeoutRst    = 16'd3000;
  localparam logic [3:0]  MaxRetriesRst    = 4'd3;
  localparam logic        ReliabilityOnRst = 1'b1;

  localparam logic [1:0] RegAckTimeout    = 2'd0;
  localparam logic [1:0] RegMaxRetries    = 2'd1;
  localparam logic [1:0] RegReliabilityOn = 2'd2;

  localparam logic [1:0] ActSend = 2'd0;
  localparam logic [1:0] ActAck  = 2'd1;
  localparam logic [1:0] ActTick = 2'd2;

  localparam logic [2:0] KindTx     = 3'd0;
  localparam logic [2:0] KindRetx   = 3'd1;
  localparam logic [2:0] KindAckOk  = 3'd2;
  localparam logic [2:0] KindAckBad = 3'd3;
  localparam logic [2:0] KindGiveUp = 3'd4;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] handle;
    logic [31:0] sent;
    logic [3:0]  retries;
  } slot_t;

  typedef struct packed {
    logic shift;
    logic wr;
  } cell_ctl_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] seq;
    logic [31:0] handle;
    logic        needs_ack;
    logic        tracked;
    logic [3:0]  retries;
    logic        last;
  } res_t;

endpackage

// ===== src/art_cell.sv =====
// one table slot of the ring, shifts to its neighbor during a scan
module art_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  art_pkg::cell_ctl_t ctl_i,
  input  logic              nbr_valid_i,
  input  art_pkg::slot_t    nbr_slot_i,
  input  logic              wr_valid_i,
  input  art_pkg::slot_t    wr_slot_i,
  output logic              valid_o,
  output art_pkg::slot_t    slot_o
);

  logic           valid_q, valid_d;
  art_pkg::slot_t slot_q, slot_d;

  always_comb begin
    valid_d = valid_q;
    slot_d  = slot_q;
    if (ctl_i.shift) begin
      valid_d = nbr_valid_i;
      slot_d  = nbr_slot_i;
    end else if (ctl_i.wr) begin
      valid_d = wr_valid_i;
      slot_d  = wr_slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign valid_o = valid_q;
  assign slot_o  = slot_q;

endmodule

// ===== src/art_mod.sv =====
// remainder of a 32-bit number by the slot count, by folding and reciprocal multiplication
module art_mod #(
  parameter int unsigned SLOTS = art_pkg::SlotsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [31:0]                x_i,
  output logic                       done_o,
  output logic [$clog2(SLOTS)-1:0]   rem_o
);

  localparam int unsigned IW      = $clog2(SLOTS);
  localparam logic [7:0]  Fold    = 8'(65536 % SLOTS);
  localparam logic [31:0] Recip   = 32'(((64'd1 << 32) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));
  localparam logic [23:0] Modulus = 24'(SLOTS);

  logic          v1_q, v2_q, v3_q;
  logic [23:0]   fold_q, fold_d;
  logic [23:0]   quo_q, quo_d;
  logic [55:0]   prod;
  logic [23:0]   diff;
  logic [IW-1:0] rem_q, rem_d;

  // upper half folded onto the lower half keeps the remainder
  assign fold_d = 24'(x_i[31:16]) * 24'(Fold) + 24'(x_i[15:0]);
  assign prod   = 56'(fold_q) * 56'(Recip);
  assign quo_d  = prod[55:32];
  assign diff   = fold_q - quo_q * Modulus;
  assign rem_d  = diff[IW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      fold_q <= fold_d;
    end
    if (v1_q) begin
      quo_q <= quo_d;
    end
    if (v2_q) begin
      rem_q <= rem_d;
    end
  end

  assign done_o = v3_q;
  assign rem_o  = rem_q;

endmodule

// ===== src/ack_retransmit_tracker_unit.sv =====
// top level of the sender-side ack tracker with timeout and retransmission
// usage:
//   s_axis carries one item per transfer: tuser = action (send, ack, tick),
//   tdata = payload and ack sequence number.
//   m_axis carries result items: tuser = kind, tlast marks the final result
//   of an input, tdata = seq, handle, needs_ack, tracked, retry_count.
//   an apb port holds ack_timeout, max_retries and reliability_on.
//   send and ack compute seq mod SLOTS in a remainder unit that registers a folded
//   value, a quotient and the remainder, then touch the slot and load the result.
//   a tick rotates the ring of SLOTS cells once, one cell a cycle unless a new result
//   waits behind a pending one on a stalled output, then hands over its final result.
//   one result stays pending so that tlast can be set on the final one.
//   the next item is taken when the block is idle and the output register
//   is free or being drained.
//   reset empties the table, sets time to 0, next sequence number to 1
//   and loads the register defaults.
//   a stalled m_axis holds its result and the scan waits for it when another result is due.
module ack_retransmit_tracker_unit #(
  parameter int unsigned SLOTS = art_pkg::SlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // payload, ack_seq
  input  logic [1:0]  s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // seq, packet_handle, needs_ack, tracked, retry_count
  output logic [2:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LastStep = IW'(SLOTS - 1);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StMod   = 3'd1;
  localparam logic [2:0] StApply = 3'd2;
  localparam logic [2:0] StScan  = 3'd3;
  localparam logic [2:0] StFlush = 3'd4;

  logic [2:0] state_q, state_d;

  logic [15:0] ack_timeout_q;
  logic [3:0]  max_retries_q;
  logic        rel_q;

  logic [31:0] now_q, now_d;
  logic [31:0] next_seq_q, next_seq_d;
  logic [1:0]  act_q;
  logic [31:0] payload_q, aseq_q;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] step_q, step_d;
  logic [art_pkg::CntW-1:0] cnt_q, cnt_d;

  art_pkg::res_t out_q, out_d, pend_q, pend_d;
  logic          out_v_q, out_v_d, pend_v_q, pend_v_d;

  logic           cell_valid [SLOTS];
  art_pkg::slot_t cell_slot  [SLOTS];
  art_pkg::cell_ctl_t cell_ctl [SLOTS];

  logic           wr_valid;
  art_pkg::slot_t wr_slot;
  logic           wr_en;
  logic           tail_valid;
  art_pkg::slot_t tail_slot;
  logic           shift;

  logic           in_acc, cfg_wr, out_free;
  logic           mod_done;
  logic [IW-1:0]  mod_rem;
  logic           hit, can_step;
  logic [31:0]    age;
  art_pkg::res_t  new_res;
  logic           sel_valid;
  art_pkg::slot_t sel_slot;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign out_free = !out_v_q || m_axis_tready;
  assign s_axis_tready = (state_q == StIdle) && out_free;
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  always_comb begin
    case (paddr[3:2])
      art_pkg::RegAckTimeout:    prdata = {16'd0, ack_timeout_q};
      art_pkg::RegMaxRetries:    prdata = {28'd0, max_retries_q};
      art_pkg::RegReliabilityOn: prdata = {31'd0, rel_q};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_timeout_q <= art_pkg::AckTimeoutRst;
      max_retries_q <= art_pkg::MaxRetriesRst;
      rel_q         <= art_pkg::ReliabilityOnRst;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        art_pkg::RegAckTimeout:    ack_timeout_q <= pwdata[15:0];
        art_pkg::RegMaxRetries:    max_retries_q <= pwdata[3:0];
        art_pkg::RegReliabilityOn: rel_q         <= pwdata[0];
        default: ;
      endcase
    end
  end

  art_mod #(.SLOTS(SLOTS)) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc && (s_axis_tuser == art_pkg::ActSend || s_axis_tuser == art_pkg::ActAck)),
    .x_i     ((s_axis_tuser == art_pkg::ActSend) ? next_seq_q : s_axis_tdata[63:32]),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  assign sel_valid = cell_valid[idx_q];
  assign sel_slot  = cell_slot[idx_q];

  // scan of the head cell
  assign age = now_q - cell_slot[0].sent;

  always_comb begin
    hit        = (state_q == StScan) && cell_valid[0] && (age > {16'd0, ack_timeout_q})
                 && (cnt_q < art_pkg::CntW'(art_pkg::MaxResults));
    tail_valid = cell_valid[0];
    tail_slot  = cell_slot[0];
    new_res    = '0;
    new_res.seq    = cell_slot[0].seq;
    new_res.handle = cell_slot[0].handle;
    if (cell_slot[0].retries < max_retries_q) begin
      tail_slot.retries = cell_slot[0].retries + 4'd1;
      tail_slot.sent    = now_q;
      new_res.kind      = art_pkg::KindRetx;
      new_res.needs_ack = 1'b1;
      new_res.tracked   = 1'b1;
      new_res.retries   = cell_slot[0].retries + 4'd1;
    end else begin
      new_res.kind    = art_pkg::KindGiveUp;
      new_res.retries = cell_slot[0].retries;
    end
    if (!hit) begin
      tail_slot = cell_slot[0];
    end else if (new_res.kind == art_pkg::KindGiveUp) begin
      tail_valid = 1'b0;
    end
  end

  assign can_step = !hit || !pend_v_q || out_free;
  assign shift    = (state_q == StScan) && can_step;

  always_comb begin
    state_d    = state_q;
    now_d      = now_q;
    next_seq_d = next_seq_q;
    idx_d      = idx_q;
    step_d     = step_q;
    cnt_d      = cnt_q;
    out_d      = out_q;
    out_v_d    = out_v_q && !m_axis_tready;
    pend_d     = pend_q;
    pend_v_d   = pend_v_q;
    wr_en      = 1'b0;
    wr_valid   = 1'b0;
    wr_slot    = sel_slot;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          case (s_axis_tuser)
            art_pkg::ActSend, art_pkg::ActAck: state_d = StMod;
            art_pkg::ActTick: begin
              now_d   = now_q + 32'd1;
              step_d  = '0;
              cnt_d   = '0;
              state_d = StScan;
            end
            default: ;
          endcase
        end
      end
      StMod: begin
        if (mod_done) begin
          idx_d   = mod_rem;
          state_d = StApply;
        end
      end
      StApply: begin
        if (out_free) begin
          out_v_d = 1'b1;
          out_d   = '0;
          out_d.last = 1'b1;
          if (act_q == art_pkg::ActSend) begin
            out_d.kind      = art_pkg::KindTx;
            out_d.seq       = next_seq_q;
            out_d.handle    = payload_q;
            out_d.needs_ack = rel_q;
            out_d.tracked   = rel_q && !sel_valid;
            next_seq_d      = next_seq_q + 32'd1;
            wr_en           = rel_q && !sel_valid;
            wr_valid        = 1'b1;
            wr_slot.seq     = next_seq_q;
            wr_slot.handle  = payload_q;
            wr_slot.sent    = now_q;
            wr_slot.retries = '0;
          end else begin
            out_d.seq = aseq_q;
            if (sel_valid && sel_slot.seq == aseq_q) begin
              out_d.kind    = art_pkg::KindAckOk;
              out_d.handle  = sel_slot.handle;
              out_d.retries = sel_slot.retries;
              wr_en         = 1'b1;
            end else begin
              out_d.kind = art_pkg::KindAckBad;
            end
          end
          state_d = StIdle;
        end
      end
      StScan: begin
        if (can_step) begin
          if (hit) begin
            cnt_d    = cnt_q + art_pkg::CntW'(1);
            pend_d   = new_res;
            pend_v_d = 1'b1;
            if (pend_v_q) begin
              out_d   = pend_q;
              out_v_d = 1'b1;
            end
          end
          step_d = step_q + IW'(1);
          if (step_q == LastStep) begin
            state_d = StFlush;
          end
        end
      end
      StFlush: begin
        if (!pend_v_q) begin
          state_d = StIdle;
        end else if (out_free) begin
          out_d      = pend_q;
          out_d.last = 1'b1;
          out_v_d    = 1'b1;
          pend_v_d   = 1'b0;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    assign cell_ctl[i].shift = shift;
    assign cell_ctl[i].wr    = wr_en && (idx_q == IW'(i));
    if (i == SLOTS - 1) begin : g_tail
      art_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctl_i       (cell_ctl[i]),
        .nbr_valid_i (tail_valid),
        .nbr_slot_i  (tail_slot),
        .wr_valid_i  (wr_valid),
        .wr_slot_i   (wr_slot),
        .valid_o     (cell_valid[i]),
        .slot_o      (cell_slot[i])
      );
    end else begin : g_body
      art_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctl_i       (cell_ctl[i]),
        .nbr_valid_i (cell_valid[i+1]),
        .nbr_slot_i  (cell_slot[i+1]),
        .wr_valid_i  (wr_valid),
        .wr_slot_i   (wr_slot),
        .valid_o     (cell_valid[i]),
        .slot_o      (cell_slot[i])
      );
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      now_q      <= '0;
      next_seq_q <= 32'd1;
      step_q     <= '0;
      cnt_q      <= '0;
      out_v_q    <= 1'b0;
      pend_v_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      now_q      <= now_d;
      next_seq_q <= next_seq_d;
      step_q     <= step_d;
      cnt_q      <= cnt_d;
      out_v_q    <= out_v_d;
      pend_v_q   <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
    idx_q  <= idx_d;
    if (in_acc) begin
      act_q     <= s_axis_tuser;
      payload_q <= s_axis_tdata[31:0];
      aseq_q    <= s_axis_tdata[63:32];
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {2'b00, out_q.retries, out_q.tracked, out_q.needs_ack,
                          out_q.handle, out_q.seq};

  a_idle_no_pend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !pend_v_q)
    else $error("pending result left over in idle");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= art_pkg::CntW'(art_pkg::MaxResults))
    else $error("result count per tick overflow");

  a_scan_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan && step_q == LastStep && can_step) |=> state_q == StFlush)
    else $error("scan did not end after a full rotation");

endmodule

// ===== bench/art_checker.sv =====
// checker for the ack retransmit tracker: predicts results and compares them
`timescale 1ns / 100ps
module art_checker #(
  parameter int unsigned SLOTS = art_pkg::SlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_cnt,
  output int          pending
);

  logic [15:0] timeout_q;
  logic [3:0]  retries_max_q;
  logic        rel_q;
  logic [31:0] now_q;
  logic [31:0] seq_next_q;
  logic        busy_q [SLOTS];
  art_pkg::slot_t entry_q [SLOTS];
  art_pkg::res_t  due_results [$];

  function automatic art_pkg::res_t mk(logic [2:0] kind, logic [31:0] seq,
                                       logic [31:0] hnd, logic need, logic trk,
                                       logic [3:0] rc);
    art_pkg::res_t r;
    r.kind = kind;
    r.seq = seq;
    r.handle = hnd;
    r.needs_ack = need;
    r.tracked = trk;
    r.retries = rc;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic track_item(logic [1:0] act, logic [31:0] payload, logic [31:0] aseq);
    int unsigned s;
    int n;
    logic trk;
    logic [31:0] seq;
    n = 0;
    if (act == art_pkg::ActSend) begin
      seq = seq_next_q;
      s = seq % SLOTS;
      trk = 1'b0;
      seq_next_q = seq + 32'd1;
      if (rel_q && !busy_q[s]) begin
        busy_q[s] = 1'b1;
        entry_q[s] = '{seq: seq, handle: payload, sent: now_q, retries: 4'd0};
        trk = 1'b1;
      end
      due_results.push_back(mk(art_pkg::KindTx, seq, payload, rel_q, trk, 4'd0));
      n = 1;
    end else if (act == art_pkg::ActAck) begin
      s = aseq % SLOTS;
      if (busy_q[s] && entry_q[s].seq == aseq) begin
        busy_q[s] = 1'b0;
        due_results.push_back(mk(art_pkg::KindAckOk, aseq, entry_q[s].handle, 1'b0,
                                 1'b0, entry_q[s].retries));
      end else begin
        due_results.push_back(mk(art_pkg::KindAckBad, aseq, 32'd0, 1'b0, 1'b0, 4'd0));
      end
      n = 1;
    end else if (act == art_pkg::ActTick) begin
      now_q = now_q + 32'd1;
      for (int i = 0; i < SLOTS && n < art_pkg::MaxResults; i++) begin
        if (busy_q[i] && (now_q - entry_q[i].sent) > {16'd0, timeout_q}) begin
          if (entry_q[i].retries < retries_max_q) begin
            entry_q[i].retries = entry_q[i].retries + 4'd1;
            entry_q[i].sent = now_q;
            due_results.push_back(mk(art_pkg::KindRetx, entry_q[i].seq,
                                     entry_q[i].handle, 1'b1, 1'b1,
                                     entry_q[i].retries));
          end else begin
            busy_q[i] = 1'b0;
            due_results.push_back(mk(art_pkg::KindGiveUp, entry_q[i].seq,
                                     entry_q[i].handle, 1'b0, 1'b0,
                                     entry_q[i].retries));
          end
          n++;
        end
      end
    end
    if (n > 0) due_results[$].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    art_pkg::res_t want;
    art_pkg::res_t got;
    if (!rst_ni) begin
      timeout_q = art_pkg::AckTimeoutRst;
      retries_max_q = art_pkg::MaxRetriesRst;
      rel_q = art_pkg::ReliabilityOnRst;
      now_q = '0;
      seq_next_q = 32'd1;
      for (int i = 0; i < SLOTS; i++) busy_q[i] = 1'b0;
      due_results.delete();
      fail_cnt = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tuser;
        got.seq = m_axis_tdata[31:0];
        got.handle = m_axis_tdata[63:32];
        got.needs_ack = m_axis_tdata[64];
        got.tracked = m_axis_tdata[65];
        got.retries = m_axis_tdata[69:66];
        got.last = m_axis_tlast;
        if (due_results.size() == 0) begin
          $error("unexpected result transfer kind %0d seq %0d", got.kind, got.seq);
          fail_cnt++;
        end else begin
          want = due_results.pop_front();
          if (got.kind !== want.kind) begin
            $error("kind: expected %0d actual %0d", want.kind, got.kind);
            fail_cnt++;
          end
          if (got.seq !== want.seq) begin
            $error("seq: expected %0d actual %0d", want.seq, got.seq);
            fail_cnt++;
          end
          if (got.handle !== want.handle) begin
            $error("packet_handle: expected %h actual %h", want.handle, got.handle);
            fail_cnt++;
          end
          if (got.needs_ack !== want.needs_ack) begin
            $error("needs_ack: expected %0d actual %0d", want.needs_ack, got.needs_ack);
            fail_cnt++;
          end
          if (got.tracked !== want.tracked) begin
            $error("tracked: expected %0d actual %0d", want.tracked, got.tracked);
            fail_cnt++;
          end
          if (got.retries !== want.retries) begin
            $error("retry_count: expected %0d actual %0d", want.retries, got.retries);
            fail_cnt++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d actual %0d", want.last, got.last);
            fail_cnt++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        track_item(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          art_pkg::RegAckTimeout: begin
            timeout_q = pwdata[15:0];
          end
          art_pkg::RegMaxRetries: begin
            retries_max_q = pwdata[3:0];
          end
          art_pkg::RegReliabilityOn: begin
            rel_q = pwdata[0];
          end
          default: begin
          end
        endcase
      end
    end
    pending = due_results.size();
  end

endmodule

// ===== bench/ack_retransmit_tracker_unit_tb.sv =====
// testbench top of the ack retransmit tracker: stimulus, stalls and verdict
`timescale 1ns / 100ps
module ack_retransmit_tracker_unit_tb;

  localparam int unsigned SLOTS = 16;
  localparam logic [1:0] ActIgnored = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // payload, ack_seq
  logic [1:0]  s_axis_tuser;   // action
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // seq, packet_handle, needs_ack, tracked, retry_count
  logic [2:0]  m_axis_tuser;   // kind
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_cnt;
  int          pending;
  int          stall_left;
  int unsigned sends_done;
  bit          no_stalls;

  ack_retransmit_tracker_unit #(.SLOTS(SLOTS)) u_top (.*);

  art_checker #(.SLOTS(SLOTS)) u_checker (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (no_stalls || p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // random backpressure on the result side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      stall_left = gap_len();
      m_axis_tready <= (stall_left == 0);
    end
  end

  task automatic push_item(logic [1:0] act, logic [31:0] payload, logic [31:0] aseq);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {aseq, payload};
    if (act == art_pkg::ActSend) sends_done++;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (SLOTS + 30) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_mode(logic [15:0] tmo, logic [3:0] rmax, logic rel);
    reg_write(art_pkg::RegAckTimeout, {16'd0, tmo});
    reg_write(art_pkg::RegMaxRetries, {28'd0, rmax});
    reg_write(art_pkg::RegReliabilityOn, {31'd0, rel});
  endtask

  task automatic random_items(int cnt);
    int p;
    logic [31:0] aseq;
    for (int k = 0; k < cnt; k++) begin
      p = $urandom_range(0, 99);
      if (p < 35) begin
        push_item(art_pkg::ActSend, $urandom(), $urandom());
      end else if (p < 60) begin
        aseq = sends_done - $urandom_range(0, 20);
        push_item(art_pkg::ActAck, $urandom(), aseq);
      end else if (p < 66) begin
        push_item(art_pkg::ActAck, $urandom(), $urandom());
      end else if (p < 96) begin
        push_item(art_pkg::ActTick, $urandom(), $urandom());
      end else begin
        push_item(ActIgnored, $urandom(), $urandom());
      end
    end
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = art_pkg::ActSend;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sends_done = 0;
    no_stalls = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_mode(16'd0, 4'd1, 1'b1);
    push_item(art_pkg::ActSend, 32'h0000_0000, 32'h0);
    push_item(art_pkg::ActSend, 32'hFFFF_FFFF, 32'h0);
    push_item(art_pkg::ActAck, 32'h0, 32'd1);
    push_item(art_pkg::ActAck, 32'h0, 32'd1);
    push_item(art_pkg::ActAck, 32'h0, 32'h0000_0000);
    push_item(art_pkg::ActAck, 32'h0, 32'hFFFF_FFFF);
    push_item(art_pkg::ActTick, 32'h0, 32'h0);
    push_item(art_pkg::ActTick, 32'h0, 32'h0);
    push_item(art_pkg::ActTick, 32'h0, 32'h0);
    push_item(ActIgnored, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(art_pkg::ActSend, 32'h1234_5678, 32'h0);
    push_item(art_pkg::ActTick, 32'h0, 32'h0);
    push_item(art_pkg::ActAck, 32'h0, 32'd3);
    drain();
    set_mode(16'hFFFF, 4'hF, 1'b0);
    push_item(art_pkg::ActSend, 32'hA5A5_5A5A, 32'h0);
    push_item(art_pkg::ActAck, 32'h0, 32'd4);
    push_item(art_pkg::ActTick, 32'h0, 32'h0);
    drain();

    no_stalls = 1'b1;
    set_mode(art_pkg::AckTimeoutRst, art_pkg::MaxRetriesRst, 1'b1);
    random_items(30);
    no_stalls = 1'b0;
    set_mode(16'd0, 4'd0, 1'b1);
    random_items(35);
    set_mode(16'd2, 4'hF, 1'b1);
    random_items(40);
    set_mode(16'hFFFF, 4'hF, 1'b0);
    random_items(25);
    set_mode(16'd1, 4'd3, 1'b1);
    random_items(40);
    set_mode(16'd5, 4'd1, 1'b1);
    random_items(40);

    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
